// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the ring engine (ptrs_back).
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// File: rtl/ptrs_pkg.sv
// ---------------------------------------------------------------------------
// ptrs_pkg
// Sizes, codes and types of the per-target packet ring steering block.
// ---------------------------------------------------------------------------
package ptrs_pkg;

   localparam int RING_COUNT      = 16;
   localparam int RING_DEPTH      = 256;
   localparam int MAX_DRAIN_BATCH = 32;
   localparam int CMDQ_DEPTH      = 2;

   localparam int RING_W    = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
   localparam int SLOT_W    = $clog2(RING_DEPTH);
   localparam int PTR_MOD   = 2 * RING_DEPTH;
   localparam int PTR_W     = $clog2(PTR_MOD);
   localparam int MEM_DEPTH = RING_COUNT * RING_DEPTH;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int BATCH_W   = $clog2(MAX_DRAIN_BATCH + 1);
   localparam int QPTR_W    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int QCNT_W    = $clog2(CMDQ_DEPTH + 1);

   localparam int CPU_W      = 8;
   localparam int COUNT_W    = 5;
   localparam int BSIZE_W    = 6;
   localparam int HANDLE_W   = 32;
   localparam int PORT_W     = 16;
   localparam int FILTER_W   = 8;
   localparam int DEPTH_W    = 9;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 72;

   typedef enum logic [0:0] {
      OP_ENQUEUE = 1'b0,
      OP_DRAIN   = 1'b1
   } ptrs_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ENQUEUED = 3'd0,
      ST_DROPPED  = 3'd1,
      ST_INVALID  = 3'd2,
      ST_INACTIVE = 3'd3,
      ST_DRAINED  = 3'd4,
      ST_EMPTY    = 3'd5
   } ptrs_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CPU_BASE    = 2'd0,
      CSR_CPU_COUNT   = 2'd1,
      CSR_BATCH_SIZE  = 2'd2,
      CSR_MAP_ACTIVE  = 2'd3
   } ptrs_csr_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_EXEC,
      BK_DRAIN
   } ptrs_back_state_type;

   typedef struct packed {
      logic                deep_copy;
      logic [FILTER_W-1:0] filter;
      logic [PORT_W-1:0]   port;
      logic [HANDLE_W-1:0] handle;
   } ptrs_desc_type;

   localparam int DESC_W = $bits(ptrs_desc_type);

   typedef struct packed {
      ptrs_op_type        op;
      logic               tgt_ok;
      logic               active;
      logic [RING_W-1:0]  ring;
      logic [BATCH_W-1:0] batch;
      ptrs_desc_type      desc;
   } ptrs_cmd_type;

   typedef struct packed {
      ptrs_status_type    status;
      ptrs_desc_type      desc;
      logic [DEPTH_W-1:0] depth;
      logic               more;
      logic               last;
   } ptrs_rsp_type;

endpackage

// File: rtl/ptrs_front.sv
// ---------------------------------------------------------------------------
// ptrs_front
// Register file and request classifier: window lookup and batch clamp.
// ---------------------------------------------------------------------------
module ptrs_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ptrs_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   input  logic                                csr_we,
   input  logic [ptrs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptrs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                push_valid,
   input  logic                                push_ready,
   output ptrs_pkg::ptrs_cmd_type              push_cmd
);
   import ptrs_pkg::*;

   localparam int CMP_W  = CPU_W + 1;
   localparam int BSEL_W = 8;

   logic [CPU_W-1:0]   cpu_base_ff, cpu_base_in;
   logic [COUNT_W-1:0] cpu_count_ff, cpu_count_in;
   logic [BSIZE_W-1:0] batch_ff, batch_in;
   logic               active_ff, active_in;

   logic [CPU_W-1:0]   cpu;
   logic [CMP_W-1:0]   diff;
   logic [CMP_W-1:0]   count_wide;
   logic [CMP_W-1:0]   limit;
   logic [BSEL_W-1:0]  bsize_wide;
   logic [BSEL_W-1:0]  bsize_eff;

   always_comb begin
      cpu_base_in  = cpu_base_ff;
      cpu_count_in = cpu_count_ff;
      batch_in     = batch_ff;
      active_in    = active_ff;
      if (csr_we) begin
         case (ptrs_csr_type'(csr_index))
            CSR_CPU_BASE:   cpu_base_in  = csr_wdata[CPU_W-1:0];
            CSR_CPU_COUNT:  cpu_count_in = csr_wdata[COUNT_W-1:0];
            CSR_BATCH_SIZE: batch_in     = csr_wdata[BSIZE_W-1:0];
            CSR_MAP_ACTIVE: active_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_base_ff  <= '0;
         cpu_count_ff <= COUNT_W'(16);
         batch_ff     <= BSIZE_W'(32);
         active_ff    <= 1'b1;
      end else begin
         cpu_base_ff  <= cpu_base_in;
         cpu_count_ff <= cpu_count_in;
         batch_ff     <= batch_in;
         active_ff    <= active_in;
      end
   end

   assign cpu        = req_tdata[CPU_W-1:0];
   assign diff       = {1'b0, cpu} - {1'b0, cpu_base_ff};
   assign count_wide = CMP_W'(cpu_count_ff);
   assign limit      = (count_wide > CMP_W'(RING_COUNT)) ? CMP_W'(RING_COUNT) : count_wide;
   assign bsize_wide = BSEL_W'(batch_ff);
   assign bsize_eff  = (bsize_wide == '0 || bsize_wide > BSEL_W'(MAX_DRAIN_BATCH)) ?
                       BSEL_W'(MAX_DRAIN_BATCH) : bsize_wide;

   always_comb begin
      push_cmd        = '0;
      push_cmd.op     = ptrs_op_type'(req_tuser);
      push_cmd.tgt_ok = !diff[CMP_W-1] && (diff < limit);
      push_cmd.active = active_ff;
      push_cmd.ring   = RING_W'(diff);
      push_cmd.batch  = BATCH_W'(bsize_eff);
      push_cmd.desc   = ptrs_desc_type'(req_tdata[CPU_W +: DESC_W]);
   end

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

endmodule

// File: rtl/ptrs_cmd_fifo.sv
// ---------------------------------------------------------------------------
// ptrs_cmd_fifo
// Short command queue between the classifier and the ring engine.
// ---------------------------------------------------------------------------
module ptrs_cmd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  ptrs_pkg::ptrs_cmd_type push_cmd,
   output logic                   pop_valid,
   input  logic                   pop,
   output ptrs_pkg::ptrs_cmd_type pop_cmd
);
   import ptrs_pkg::*;

   ptrs_cmd_type        q_ff [CMDQ_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push_go;
   logic                pop_go;

   function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign push_ready = (count_ff != QCNT_W'(CMDQ_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_go    = push_valid && push_ready;
   assign pop_go     = pop && pop_valid;
   assign pop_cmd    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_go ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop_go ? bump(rd_ptr_ff) : rd_ptr_ff;
      case ({push_go, pop_go})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_go) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/ptrs_back.sv
// ---------------------------------------------------------------------------
// ptrs_back
// Ring engine: head/tail pointers, descriptor memory and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ptrs_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_pop,
   input  ptrs_pkg::ptrs_cmd_type cmd,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ptrs_pkg::ptrs_rsp_type rsp
);
   import ptrs_pkg::*;

   ptrs_back_state_type state_ff, state_in;
   ptrs_cmd_type        cmd_ff, cmd_in;

   logic [PTR_W-1:0]    head_ff [RING_COUNT];
   logic [PTR_W-1:0]    head_in [RING_COUNT];
   logic [PTR_W-1:0]    tail_ff [RING_COUNT];
   logic [PTR_W-1:0]    tail_in [RING_COUNT];

   logic [PTR_W-1:0]    occ_ff, occ_in;
   logic [BATCH_W-1:0]  left_ff, left_in;

   logic                pend_valid_ff, pend_valid_in;
   logic [DEPTH_W-1:0]  pend_depth_ff, pend_depth_in;
   logic                pend_more_ff, pend_more_in;
   logic                pend_last_ff, pend_last_in;

   ptrs_desc_type       desc_mem_ff [MEM_DEPTH];
   ptrs_desc_type       rdata_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   ptrs_rsp_type        rsp_ff, rsp_in;
   logic                rsp_load;

   logic [PTR_W-1:0]    head_sel;
   logic [PTR_W-1:0]    tail_sel;
   logic [PTR_W:0]      occ_wide;
   logic [PTR_W-1:0]    occ;
   logic                ring_full;
   logic                out_free;
   logic                pend_take;
   logic                exec_go;
   logic                issue;
   logic                fin;
   logic                wr_en;
   logic                rd_en;
   logic [MEM_AW-1:0]   ring_base;
   logic [MEM_AW-1:0]   wr_addr;
   logic [MEM_AW-1:0]   rd_addr;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(PTR_MOD - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
      return (p >= PTR_W'(RING_DEPTH)) ? SLOT_W'(p - PTR_W'(RING_DEPTH)) : SLOT_W'(p);
   endfunction

   assign head_sel  = head_ff[cmd_ff.ring];
   assign tail_sel  = tail_ff[cmd_ff.ring];
   assign occ_wide  = (tail_sel >= head_sel) ?
                      ({1'b0, tail_sel} - {1'b0, head_sel}) :
                      ({1'b0, tail_sel} + (PTR_W + 1)'(PTR_MOD) - {1'b0, head_sel});
   assign occ       = occ_wide[PTR_W-1:0];
   assign ring_full = (occ >= PTR_W'(RING_DEPTH));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pend_take = pend_valid_ff && out_free;
   assign exec_go   = out_free && !pend_valid_ff;
   assign issue     = !pend_valid_ff || out_free;
   assign fin       = (occ_ff == PTR_W'(1)) || (left_ff == BATCH_W'(1));
   assign ring_base = MEM_AW'(cmd_ff.ring) * MEM_AW'(RING_DEPTH);
   assign wr_addr   = ring_base + MEM_AW'(slot_of(tail_sel));
   assign rd_addr   = ring_base + MEM_AW'(slot_of(head_sel));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            if (exec_go) begin
               if (cmd_ff.op == OP_DRAIN && cmd_ff.tgt_ok && occ != '0) begin
                  state_in = BK_DRAIN;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_DRAIN: begin
            if (issue && fin) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop       = 1'b0;
      cmd_in        = cmd_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      left_in       = left_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      pend_valid_in = pend_valid_ff && !pend_take;
      pend_depth_in = pend_depth_ff;
      pend_more_in  = pend_more_ff;
      pend_last_in  = pend_last_ff;
      rsp_load      = 1'b0;
      rsp_in        = rsp_ff;

      if (pend_take) begin
         rsp_load      = 1'b1;
         rsp_in.status = ST_DRAINED;
         rsp_in.desc   = rdata_ff;
         rsp_in.depth  = pend_depth_ff;
         rsp_in.more   = pend_more_ff;
         rsp_in.last   = pend_last_ff;
      end

      case (state_ff)
         BK_IDLE: begin
            cmd_pop = cmd_valid;
            cmd_in  = cmd;
         end
         BK_EXEC: begin
            if (exec_go) begin
               if (cmd_ff.op == OP_ENQUEUE) begin
                  rsp_load    = 1'b1;
                  rsp_in.desc = cmd_ff.desc;
                  rsp_in.more = 1'b0;
                  rsp_in.last = 1'b1;
                  if (!cmd_ff.active) begin
                     rsp_in.status = ST_INACTIVE;
                     rsp_in.depth  = cmd_ff.tgt_ok ? DEPTH_W'(occ) : '0;
                  end else if (!cmd_ff.tgt_ok) begin
                     rsp_in.status = ST_INVALID;
                     rsp_in.depth  = '0;
                  end else if (ring_full) begin
                     rsp_in.status = ST_DROPPED;
                     rsp_in.depth  = DEPTH_W'(occ);
                  end else begin
                     rsp_in.status         = ST_ENQUEUED;
                     rsp_in.depth          = DEPTH_W'(occ + 1'b1);
                     wr_en                 = 1'b1;
                     tail_in[cmd_ff.ring]  = next_ptr(tail_sel);
                  end
               end else if (!cmd_ff.tgt_ok || occ == '0) begin
                  rsp_load      = 1'b1;
                  rsp_in.status = cmd_ff.tgt_ok ? ST_EMPTY : ST_INVALID;
                  rsp_in.desc   = '0;
                  rsp_in.depth  = '0;
                  rsp_in.more   = 1'b0;
                  rsp_in.last   = 1'b1;
               end else begin
                  occ_in  = occ;
                  left_in = cmd_ff.batch;
               end
            end
         end
         BK_DRAIN: begin
            if (issue) begin
               rd_en                = 1'b1;
               head_in[cmd_ff.ring] = next_ptr(head_sel);
               occ_in               = occ_ff - 1'b1;
               left_in              = left_ff - 1'b1;
               pend_valid_in        = 1'b1;
               pend_depth_in        = DEPTH_W'(occ_ff - 1'b1);
               pend_more_in         = (occ_ff != PTR_W'(1));
               pend_last_in         = fin;
            end
         end
         default: ;
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         for (int i = 0; i < RING_COUNT; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      occ_ff        <= occ_in;
      left_ff       <= left_in;
      pend_depth_ff <= pend_depth_in;
      pend_more_ff  <= pend_more_in;
      pend_last_ff  <= pend_last_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         desc_mem_ff[wr_addr] <= cmd_ff.desc;
      end
      if (rd_en) begin
         rdata_ff <= desc_mem_ff[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `ASSERT_IMPLIES(a_occ_bound, clock, reset, state_ff == BK_EXEC, occ <= PTR_W'(RING_DEPTH))
   `ASSERT_IMPLIES(a_drain_live, clock, reset, state_ff == BK_DRAIN, occ_ff != '0 && left_ff != '0)
   `ASSERT_NEXT(a_rdata_hold, clock, reset, pend_valid_ff && !pend_take, $stable(rdata_ff))
   `ASSERT_IMPLIES(a_last_when_dry, clock, reset, rsp_valid_ff && rsp_ff.status == ST_DRAINED && !rsp_ff.more, rsp_ff.last)
   `ASSERT_NEVER(a_one_mem_access, clock, reset, rd_en && wr_en)

endmodule

// File: rtl/per_target_packet_ring_steering.sv
// ---------------------------------------------------------------------------
// per_target_packet_ring_steering
// One descriptor ring per target CPU with enqueue and batched drain.
// ---------------------------------------------------------------------------
// The classifier checks each request against the CPU window and map state
// and passes it through a two-entry command queue to the ring engine, which
// owns the head/tail pointers and a single-port descriptor memory. An enqueue
// or a rejected/empty drain occupies the engine for a queue pop, then a
// pointer read and memory write. During a drain batch the memory delivers
// one descriptor per cycle, so the output rate is one result per cycle
// while rsp_tready holds high. The descriptor memory needs no clearing
// after reset, which resets the ring pointers, queue, engine and registers.
// ---------------------------------------------------------------------------
module per_target_packet_ring_steering (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // cpu_number, packet_handle, port_number, filter_id, is_deep_copy
   input  logic [ptrs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_handle, out_port, out_filter, out_deep_copy, ring_depth, more_pending
   output logic [ptrs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status
   output logic [ptrs_pkg::STATUS_W-1:0]       rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [ptrs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptrs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ptrs_pkg::*;

   logic         push_valid;
   logic         push_ready;
   ptrs_cmd_type push_cmd;
   logic         pop_valid;
   logic         pop;
   ptrs_cmd_type pop_cmd;
   ptrs_rsp_type rsp;

   ptrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   ptrs_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_cmd    (pop_cmd)
   );

   ptrs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_pop   (pop),
      .cmd       (pop_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = RSP_DATA_W'({rsp.more, rsp.depth, rsp.desc});
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

endmodule

// File: sim/ring_steering_checker.sv
// ---------------------------------------------------------------------------
// ring_steering_checker
// Watches the request, response and register ports of the ring steering
// block. It keeps its own copy of the per-CPU rings and of the registers,
// works out the response words that each accepted request must produce, and
// compares every accepted response word with the oldest one still owed.
// ---------------------------------------------------------------------------
module ring_steering_checker
   import ptrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [STATUS_W-1:0]   rsp_tuser,
   input  logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    failures,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [CPU_W-1:0]   cfg_base;
   logic [COUNT_W-1:0] cfg_count;
   logic [BSIZE_W-1:0] cfg_batch;
   logic               cfg_active;

   ptrs_desc_type slot_mem [RING_COUNT][RING_DEPTH];
   int unsigned   ring_rd   [RING_COUNT];
   int unsigned   ring_fill [RING_COUNT];

   ptrs_rsp_type owed_words[$];
   int           error_count = 0;

   task automatic owe_word(input ptrs_status_type st, input ptrs_desc_type d,
                           input int unsigned depth, input logic more,
                           input logic last);
      ptrs_rsp_type w;
      w.status = st;
      w.desc   = d;
      w.depth  = DEPTH_W'(depth);
      w.more   = more;
      w.last   = last;
      owed_words.push_back(w);
   endtask

   task automatic predict_steering(input ptrs_op_type op, input logic [CPU_W-1:0] cpu,
                                   input ptrs_desc_type d);
      int unsigned span;
      int unsigned ring;
      int unsigned batch;
      int unsigned k;
      bit          hit;
      span  = (cfg_count > RING_COUNT) ? RING_COUNT : cfg_count;
      hit   = (32'(cpu) >= 32'(cfg_base)) && (32'(cpu) < 32'(cfg_base) + span);
      ring  = hit ? 32'(cpu) - 32'(cfg_base) : 0;
      batch = (cfg_batch == 0 || cfg_batch > MAX_DRAIN_BATCH) ? MAX_DRAIN_BATCH : cfg_batch;
      if (op == OP_ENQUEUE) begin
         if (!cfg_active) begin
            owe_word(ST_INACTIVE, d, hit ? ring_fill[ring] : 0, 1'b0, 1'b1);
         end else if (!hit) begin
            owe_word(ST_INVALID, d, 0, 1'b0, 1'b1);
         end else if (ring_fill[ring] >= RING_DEPTH) begin
            owe_word(ST_DROPPED, d, ring_fill[ring], 1'b0, 1'b1);
         end else begin
            slot_mem[ring][(ring_rd[ring] + ring_fill[ring]) % RING_DEPTH] = d;
            ring_fill[ring]++;
            owe_word(ST_ENQUEUED, d, ring_fill[ring], 1'b0, 1'b1);
         end
      end else if (!hit) begin
         owe_word(ST_INVALID, '0, 0, 1'b0, 1'b1);
      end else if (ring_fill[ring] == 0) begin
         owe_word(ST_EMPTY, '0, 0, 1'b0, 1'b1);
      end else begin
         k = 0;
         while (ring_fill[ring] != 0 && k < batch) begin
            d = slot_mem[ring][ring_rd[ring]];
            ring_rd[ring] = (ring_rd[ring] + 1) % RING_DEPTH;
            ring_fill[ring]--;
            k++;
            owe_word(ST_DRAINED, d, ring_fill[ring], ring_fill[ring] != 0,
                     ring_fill[ring] == 0 || k >= batch);
         end
      end
   endtask

   task automatic flag_error(input string what, input ptrs_rsp_type want,
                             input ptrs_rsp_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s", $realtime, what);
         $display("   expected st=%0d h=%h p=%h f=%h dc=%0d depth=%0d more=%0d last=%0d",
                  want.status, want.desc.handle, want.desc.port, want.desc.filter,
                  want.desc.deep_copy, want.depth, want.more, want.last);
         $display("   actual   st=%0d h=%h p=%h f=%h dc=%0d depth=%0d more=%0d last=%0d",
                  got.status, got.desc.handle, got.desc.port, got.desc.filter,
                  got.desc.deep_copy, got.depth, got.more, got.last);
      end
   endtask

   always @(posedge clock) begin : monitor
      ptrs_rsp_type got;
      ptrs_rsp_type want;
      if (reset) begin
         cfg_base   = '0;
         cfg_count  = COUNT_W'(16);
         cfg_batch  = BSIZE_W'(32);
         cfg_active = 1'b1;
         for (int r = 0; r < RING_COUNT; r++) begin
            ring_rd[r]   = 0;
            ring_fill[r] = 0;
         end
         owed_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = ptrs_status_type'(rsp_tuser);
            got.desc   = rsp_tdata[DESC_W-1:0];
            got.depth  = rsp_tdata[DESC_W +: DEPTH_W];
            got.more   = rsp_tdata[DESC_W + DEPTH_W];
            got.last   = rsp_tlast;
            if (owed_words.size() == 0) begin
               flag_error("response word with none owed", '0, got);
            end else begin
               want = owed_words.pop_front();
               if (got.status !== want.status || got.desc.handle !== want.desc.handle ||
                   got.desc.port !== want.desc.port || got.desc.filter !== want.desc.filter ||
                   got.desc.deep_copy !== want.desc.deep_copy ||
                   got.depth !== want.depth || got.more !== want.more ||
                   got.last !== want.last)
                  flag_error("response word mismatch", want, got);
            end
         end
         if (req_tvalid && req_tready)
            predict_steering(ptrs_op_type'(req_tuser), req_tdata[CPU_W-1:0],
                             req_tdata[CPU_W +: DESC_W]);
         if (csr_we) begin
            case (csr_index)
               CSR_CPU_BASE:   cfg_base   = csr_wdata[CPU_W-1:0];
               CSR_CPU_COUNT:  cfg_count  = csr_wdata[COUNT_W-1:0];
               CSR_BATCH_SIZE: cfg_batch  = csr_wdata[BSIZE_W-1:0];
               CSR_MAP_ACTIVE: cfg_active = csr_wdata[0];
               default: ;
            endcase
         end
      end
      outstanding <= owed_words.size();
      failures    <= error_count;
   end

endmodule

// File: sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives the ring steering block with directed and random enqueue and drain
// requests over several register settings and idle patterns; the checker
// beside the block predicts and compares every response word.
// ---------------------------------------------------------------------------
module testbench;
   import ptrs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int failures;
   int outstanding;
   int send_idle = 0;
   int rcv_stall = 0;

   logic [CPU_W-1:0]   win_base  = '0;
   logic [COUNT_W-1:0] win_count = COUNT_W'(16);

   per_target_packet_ring_steering dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   ring_steering_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rcv_stall);
   end

   task automatic send_word(input ptrs_op_type op, input logic [CPU_W-1:0] cpu,
                            input ptrs_desc_type d);
      req_tuser  <= op;
      req_tdata  <= {7'b0, d, cpu};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (send_idle != 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
   endtask

   task automatic send_random_word();
      ptrs_desc_type     d;
      ptrs_op_type       op;
      logic [CPU_W-1:0]  cpu;
      int unsigned       span;
      d.handle    = $urandom;
      d.port      = PORT_W'($urandom);
      d.filter    = FILTER_W'($urandom);
      d.deep_copy = 1'($urandom_range(1));
      op   = ($urandom_range(99) < 60) ? OP_ENQUEUE : OP_DRAIN;
      span = (win_count > RING_COUNT) ? RING_COUNT : win_count;
      if (span != 0 && $urandom_range(99) < 85)
         cpu = CPU_W'(win_base + $urandom_range(span - 1));
      else
         cpu = CPU_W'($urandom_range(255));
      send_word(op, cpu, d);
   endtask

   // hold off until every owed word has come back, then let the engine settle
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_window(input logic [CPU_W-1:0] base, input logic [COUNT_W-1:0] count,
                             input logic [BSIZE_W-1:0] batch, input logic active);
      ptrs_csr_type idx [4];
      logic [CSR_DATA_W-1:0] val [4];
      idx[0] = CSR_CPU_BASE;   val[0] = base;
      idx[1] = CSR_CPU_COUNT;  val[1] = CSR_DATA_W'(count);
      idx[2] = CSR_BATCH_SIZE; val[2] = CSR_DATA_W'(batch);
      idx[3] = CSR_MAP_ACTIVE; val[3] = CSR_DATA_W'(active);
      win_base  = base;
      win_count = count;
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      ptrs_desc_type ones;
      ptrs_desc_type zeros;
      ptrs_desc_type any;
      ones  = '1;
      zeros = '0;
      any   = {1'b1, 8'h5a, 16'h3c3c, 32'hdeadbeef};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // defaults: base 0, sixteen rings, batch 32, map active
      send_word(OP_DRAIN, 8'd0, zeros);
      send_word(OP_ENQUEUE, 8'd0, ones);
      send_word(OP_ENQUEUE, 8'd0, zeros);
      send_word(OP_ENQUEUE, 8'd15, any);
      send_word(OP_ENQUEUE, 8'd16, any);
      send_word(OP_ENQUEUE, 8'd255, ones);
      send_word(OP_DRAIN, 8'd0, ones);
      send_word(OP_DRAIN, 8'd200, zeros);

      settle();
      set_window(8'd0, 5'd16, 6'd32, 1'b0);
      send_word(OP_ENQUEUE, 8'd15, ones);
      send_word(OP_ENQUEUE, 8'd100, any);
      send_word(OP_DRAIN, 8'd15, zeros);

      settle();
      set_window(8'd255, 5'd1, 6'd1, 1'b1);
      send_word(OP_ENQUEUE, 8'd255, ones);
      send_word(OP_ENQUEUE, 8'd255, any);
      send_word(OP_ENQUEUE, 8'd255, zeros);
      send_word(OP_ENQUEUE, 8'd0, any);
      send_word(OP_DRAIN, 8'd255, zeros);
      send_word(OP_DRAIN, 8'd254, zeros);

      settle();
      set_window(8'd255, 5'd0, 6'd33, 1'b1);
      send_word(OP_ENQUEUE, 8'd255, any);
      send_word(OP_DRAIN, 8'd255, zeros);

      // overfill one ring, then empty it batch by batch
      settle();
      set_window(8'd0, 5'd16, 6'd63, 1'b1);
      for (int i = 0; i < RING_DEPTH + 2; i++) begin
         any.handle = $urandom;
         any.port   = PORT_W'($urandom);
         send_word(OP_ENQUEUE, 8'd3, any);
      end
      for (int i = 0; i < RING_DEPTH / MAX_DRAIN_BATCH + 1; i++)
         send_word(OP_DRAIN, 8'd3, zeros);

      for (int ph = 0; ph < 5; ph++) begin
         settle();
         case (ph)
            0: begin
               send_idle = 0;  rcv_stall = 0;
               set_window(8'd0, 5'd16, 6'd0, 1'b1);
            end
            1: begin
               send_idle = 84; rcv_stall = 0;
               set_window(8'd250, 5'd31, 6'd1, 1'b1);
            end
            2: begin
               send_idle = 0;  rcv_stall = 84;
               set_window(8'd128, 5'd3, 6'd63, 1'b1);
            end
            3: begin
               send_idle = 32; rcv_stall = 32;
               set_window(CPU_W'($urandom), COUNT_W'($urandom), BSIZE_W'($urandom),
                          1'($urandom_range(1)));
            end
            default: begin
               send_idle = 32; rcv_stall = 32;
               set_window(8'd0, 5'd2, 6'd32, 1'b1);
            end
         endcase
         for (int i = 0; i < 40; i++)
            send_random_word();
      end

      settle();
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
